// ----- hw/rtl/pge_pkg.sv -----
// Shared types, widths and codes for the point-gravity Euler step core.
package pge_pkg;

  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned MUL_A_W   = 96;
  localparam int unsigned MUL_B_W   = 34;
  localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned MUL_STEPS = MUL_B_W;
  localparam int unsigned MAG_W     = 33;
  localparam int unsigned DSQ_W     = 66;
  localparam int unsigned RAD_W     = 68;
  localparam int unsigned ROOT_W    = 34;
  localparam int unsigned REM_W     = 36;
  localparam int unsigned DEN_W     = 100;
  localparam int unsigned NUM_W     = 97;
  localparam int unsigned QUO_W     = 34;
  localparam int unsigned CNT_W     = 6;

  localparam logic [31:0] GRAV_COEF_RST    = 32'd1231190000;
  localparam logic [31:0] MIN_DIST_SQR_RST = 32'd42950;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INIT_POS_X   = 4'd0,
    REG_INIT_POS_Y   = 4'd1,
    REG_INIT_POS_Z   = 4'd2,
    REG_INIT_VEL_X   = 4'd3,
    REG_INIT_VEL_Y   = 4'd4,
    REG_INIT_VEL_Z   = 4'd5,
    REG_GRAV_COEF    = 4'd6,
    REG_MIN_DIST_SQR = 4'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MUL_OP_SQR,
    MUL_OP_DT,
    MUL_OP_NUM
  } mul_op_e;

  typedef struct packed {
    logic [15:0]        step_time;
    logic signed [31:0] attractor_x;
    logic signed [31:0] attractor_y;
    logic signed [31:0] attractor_z;
    logic [47:0]        attractor_mass;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x_out;
    logic signed [31:0] pos_y_out;
    logic signed [31:0] pos_z_out;
    logic signed [31:0] vel_x_out;
    logic signed [31:0] vel_y_out;
    logic signed [31:0] vel_z_out;
    logic               step_skipped;
  } out_item_t;

  typedef struct packed {
    logic    capture;
    logic    lane_load;
    logic    aux_load;
    mul_op_e mul_op;
    logic    mul_step;
    logic    d_load;
    logic    root_load;
    logic    root_step;
    logic    div_load;
    logic    div_step;
    logic    vel_upd;
    logic    pos_mul;
    logic    pos_upd;
    logic    out_load;
  } pge_cmd_t;

  typedef struct packed {
    logic skip;
  } pge_stat_t;

endpackage

// ----- hw/rtl/pge_mul.sv -----
// Shift-and-add multiplier: one multiplier bit per step, fixed step count.
module pge_mul (
  input  logic                        clk_i,
  input  logic                        load_i,
  input  logic                        step_i,
  input  logic [pge_pkg::MUL_A_W-1:0] a_i,
  input  logic [pge_pkg::MUL_B_W-1:0] b_i,
  output logic [pge_pkg::MUL_P_W-1:0] p_o
);
  import pge_pkg::*;

  logic [MUL_A_W-1:0] a_q;
  logic [MUL_P_W-1:0] p_q;
  logic [MUL_A_W:0]   sum;

  // The upper part accumulates while the multiplier bits shift out below.
  assign sum = {1'b0, p_q[MUL_P_W-1:MUL_B_W]} + (p_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      a_q <= a_i;
      p_q <= {{MUL_A_W{1'b0}}, b_i};
    end else if (step_i) begin
      p_q <= {sum, p_q[MUL_B_W-1:1]};
    end
  end

  assign p_o = p_q;
endmodule

// ----- hw/rtl/pge_sqrt.sv -----
// Digit-by-digit integer square root, two radicand bits per step.
module pge_sqrt (
  input  logic                       clk_i,
  input  logic                       load_i,
  input  logic                       step_i,
  input  logic [pge_pkg::DSQ_W-1:0]  rad_i,
  output logic [pge_pkg::ROOT_W-1:0] root_o
);
  import pge_pkg::*;

  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [REM_W+1:0]  rem_s;
  logic [REM_W+1:0]  trial;
  logic              ge;

  assign rem_s = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge    = rem_s >= trial;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rad_q  <= {{(RAD_W-DSQ_W){1'b0}}, rad_i};
      rem_q  <= '0;
      root_q <= '0;
    end else if (step_i) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= ge ? REM_W'(rem_s - trial) : REM_W'(rem_s);
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign root_o = root_q;
endmodule

// ----- hw/rtl/pge_div.sv -----
// Restoring divider for one axis, quotient clamped to two to the 33rd.
module pge_div (
  input  logic                      clk_i,
  input  logic                      load_i,
  input  logic                      step_i,
  input  logic [pge_pkg::NUM_W-1:0] num_i,
  input  logic [pge_pkg::DEN_W-1:0] den_i,
  output logic [pge_pkg::QUO_W-1:0] quo_o
);
  import pge_pkg::*;

  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [QUO_W-1:0] x_q;
  logic             ovf_q;
  logic [DEN_W:0]   t;
  logic             ge;
  logic [DEN_W:0]   diff;

  assign t    = {rem_q, x_q[QUO_W-1]};
  assign ge   = t >= {1'b0, den_q};
  assign diff = t - {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      den_q <= den_i;
      // A high part at or above the divisor means a quotient of 2^34 or more.
      ovf_q <= {{(DEN_W-(NUM_W-QUO_W)){1'b0}}, num_i[NUM_W-1:QUO_W]} >= den_i;
      rem_q <= {{(DEN_W-(NUM_W-QUO_W)){1'b0}}, num_i[NUM_W-1:QUO_W]};
      x_q   <= num_i[QUO_W-1:0];
    end else if (step_i) begin
      rem_q <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
      x_q   <= {x_q[QUO_W-2:0], ge};
    end
  end

  assign quo_o = (ovf_q || x_q[QUO_W-1]) ? {1'b1, {(QUO_W-1){1'b0}}} : x_q;
endmodule

// ----- hw/rtl/pge_datapath.sv -----
// Datapath: body state, configuration registers, arithmetic units and result register.
module pge_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pge_pkg::pge_cmd_t             cmd_i,
  output pge_pkg::pge_stat_t            stat_o,
  input  pge_pkg::in_item_t             in_item_i,
  output pge_pkg::out_item_t            out_item_o,
  input  logic                          cfg_we_i,
  input  logic [pge_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);
  import pge_pkg::*;

  logic signed [31:0] pos_q [3];
  logic signed [31:0] vel_q [3];
  logic [31:0]        grav_q;
  logic [31:0]        min_q;

  logic [15:0]        dt_q;
  logic [47:0]        mass_q;
  logic [MAG_W-1:0]   mag_q [3];
  logic               neg_q [3];
  logic [DSQ_W-1:0]   dsq_q;
  logic [31:0]        dp_q  [3];
  out_item_t          out_q;

  logic [31:0]        attr [3];
  logic [MAG_W-1:0]   r_w  [3];
  logic [MUL_A_W-1:0] lane_a;
  logic [MUL_B_W-1:0] lane_b [3];
  logic [MUL_A_W-1:0] aux_a;
  logic [MUL_B_W-1:0] aux_b;
  logic [MUL_P_W-1:0] lane_p [3];
  logic [MUL_P_W-1:0] aux_p;
  logic [ROOT_W-1:0]  root;
  logic [QUO_W-1:0]   quo  [3];
  logic [31:0]        vel_n [3];
  logic [31:0]        pos_n [3];
  logic [31:0]        dp_n  [3];

  assign attr[0] = in_item_i.attractor_x;
  assign attr[1] = in_item_i.attractor_y;
  assign attr[2] = in_item_i.attractor_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r_w[i] = {attr[i][31], attr[i]} - {pos_q[i][31], pos_q[i]};
    end
  end

  // Operand selection for the three axis multipliers and the shared one.
  always_comb begin
    lane_a = '0;
    aux_a  = '0;
    aux_b  = '0;
    for (int i = 0; i < 3; i++) begin
      lane_b[i] = {{(MUL_B_W-MAG_W){1'b0}}, mag_q[i]};
    end
    case (cmd_i.mul_op)
      MUL_OP_SQR: begin
        aux_a = {{(MUL_A_W-48){1'b0}}, mass_q};
        aux_b = {{(MUL_B_W-32){1'b0}}, grav_q};
      end
      MUL_OP_DT: begin
        aux_a = aux_p[MUL_A_W-1:0];
        aux_b = {{(MUL_B_W-16){1'b0}}, dt_q};
      end
      MUL_OP_NUM: begin
        lane_a = aux_p[MUL_A_W-1:0];
        aux_a  = {{(MUL_A_W-DSQ_W){1'b0}}, dsq_q};
        aux_b  = root;
      end
      default: begin
        aux_a = '0;
      end
    endcase
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    logic [MUL_A_W-1:0] a_sel;
    assign a_sel = (cmd_i.mul_op == MUL_OP_SQR)
                 ? {{(MUL_A_W-MAG_W){1'b0}}, mag_q[g]} : lane_a;

    pge_mul u_mul (
      .clk_i  (clk_i),
      .load_i (cmd_i.lane_load),
      .step_i (cmd_i.mul_step),
      .a_i    (a_sel),
      .b_i    (lane_b[g]),
      .p_o    (lane_p[g])
    );

    pge_div u_div (
      .clk_i  (clk_i),
      .load_i (cmd_i.div_load),
      .step_i (cmd_i.div_step),
      .num_i  (lane_p[g][NUM_W+31:32]),
      .den_i  (aux_p[DEN_W-1:0]),
      .quo_o  (quo[g])
    );
  end

  pge_mul u_aux_mul (
    .clk_i  (clk_i),
    .load_i (cmd_i.aux_load),
    .step_i (cmd_i.mul_step),
    .a_i    (aux_a),
    .b_i    (aux_b),
    .p_o    (aux_p)
  );

  pge_sqrt u_sqrt (
    .clk_i  (clk_i),
    .load_i (cmd_i.root_load),
    .step_i (cmd_i.root_step),
    .rad_i  (dsq_q),
    .root_o (root)
  );

  assign stat_o.skip = (dsq_q == '0) || (dsq_q < {{(DSQ_W-32){1'b0}}, min_q});

  // Velocity and position updates with saturation to the 32-bit range.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [35:0] vs;
      logic [35:0] dq;
      logic [33:0] ps;
      logic [31:0] vm;
      logic [47:0] prod;
      dq = {2'b00, quo[i]};
      vs = {{4{vel_q[i][31]}}, vel_q[i]} + (neg_q[i] ? (~dq + 36'd1) : dq);
      if (!vs[35] && (vs[34:31] != 4'h0)) begin
        vel_n[i] = 32'h7FFF_FFFF;
      end else if (vs[35] && (vs[34:31] != 4'hF)) begin
        vel_n[i] = 32'h8000_0000;
      end else begin
        vel_n[i] = vs[31:0];
      end
      vm      = vel_q[i][31] ? (~vel_q[i] + 32'd1) : vel_q[i];
      prod    = {16'h0000, vm} * {32'h0000_0000, dt_q};
      dp_n[i] = prod[47:16];
      ps = {{2{pos_q[i][31]}}, pos_q[i]}
         + (vel_q[i][31] ? (~{2'b00, dp_q[i]} + 34'd1) : {2'b00, dp_q[i]});
      if (!ps[33] && (ps[32:31] != 2'b00)) begin
        pos_n[i] = 32'h7FFF_FFFF;
      end else if (ps[33] && (ps[32:31] != 2'b11)) begin
        pos_n[i] = 32'h8000_0000;
      end else begin
        pos_n[i] = ps[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
      end
      grav_q <= GRAV_COEF_RST;
      min_q  <= MIN_DIST_SQR_RST;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_INIT_POS_X:   pos_q[0] <= cfg_data_i;
          REG_INIT_POS_Y:   pos_q[1] <= cfg_data_i;
          REG_INIT_POS_Z:   pos_q[2] <= cfg_data_i;
          REG_INIT_VEL_X:   vel_q[0] <= cfg_data_i;
          REG_INIT_VEL_Y:   vel_q[1] <= cfg_data_i;
          REG_INIT_VEL_Z:   vel_q[2] <= cfg_data_i;
          REG_GRAV_COEF:    grav_q   <= cfg_data_i;
          REG_MIN_DIST_SQR: min_q    <= cfg_data_i;
          default:          grav_q   <= grav_q;
        endcase
      end
      for (int i = 0; i < 3; i++) begin
        if (cmd_i.vel_upd) vel_q[i] <= vel_n[i];
        if (cmd_i.pos_upd) pos_q[i] <= pos_n[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      dt_q   <= in_item_i.step_time;
      mass_q <= in_item_i.attractor_mass;
      for (int i = 0; i < 3; i++) begin
        neg_q[i] <= r_w[i][MAG_W-1];
        mag_q[i] <= r_w[i][MAG_W-1] ? (~r_w[i] + MAG_W'(1)) : r_w[i];
      end
    end
    if (cmd_i.d_load) begin
      dsq_q <= lane_p[0][DSQ_W-1:0] + lane_p[1][DSQ_W-1:0] + lane_p[2][DSQ_W-1:0];
    end
    if (cmd_i.pos_mul) begin
      for (int i = 0; i < 3; i++) begin
        dp_q[i] <= dp_n[i];
      end
    end
    if (cmd_i.out_load) begin
      out_q.pos_x_out    <= pos_q[0];
      out_q.pos_y_out    <= pos_q[1];
      out_q.pos_z_out    <= pos_q[2];
      out_q.vel_x_out    <= vel_q[0];
      out_q.vel_y_out    <= vel_q[1];
      out_q.vel_z_out    <= vel_q[2];
      out_q.step_skipped <= stat_o.skip;
    end
  end

  assign out_item_o = out_q;
endmodule

// ----- hw/rtl/pge_ctrl.sv -----
// Sequencer that steps the datapath through the phases of one item.
module pge_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pge_pkg::pge_cmd_t  cmd_o,
  input  pge_pkg::pge_stat_t stat_i
);
  import pge_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQR,
    ST_SUM,
    ST_CHK,
    ST_ROOT,
    ST_PROD,
    ST_DIV,
    ST_VEL,
    ST_PMUL,
    ST_PADD,
    ST_FIN
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             first;
  logic             last;

  assign first = cnt_q == '0;
  assign last  = cnt_q == CNT_W'(MUL_STEPS);

  always_comb begin
    cmd_o       = '0;
    cmd_o.mul_op = MUL_OP_SQR;
    state_d     = state_q;
    cnt_d       = cnt_q;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          cnt_d         = '0;
          state_d       = ST_SQR;
        end
      end
      ST_SQR, ST_ROOT, ST_PROD, ST_DIV: begin
        cnt_d = last ? '0 : cnt_q + CNT_W'(1);
        case (state_q)
          ST_SQR: begin
            cmd_o.mul_op    = MUL_OP_SQR;
            cmd_o.lane_load = first;
            cmd_o.aux_load  = first;
            cmd_o.mul_step  = !first;
            if (last) state_d = ST_SUM;
          end
          ST_ROOT: begin
            cmd_o.mul_op    = MUL_OP_DT;
            cmd_o.aux_load  = first;
            cmd_o.root_load = first;
            cmd_o.mul_step  = !first;
            cmd_o.root_step = !first;
            if (last) state_d = ST_PROD;
          end
          ST_PROD: begin
            cmd_o.mul_op    = MUL_OP_NUM;
            cmd_o.lane_load = first;
            cmd_o.aux_load  = first;
            cmd_o.mul_step  = !first;
            if (last) state_d = ST_DIV;
          end
          default: begin
            cmd_o.div_load = first;
            cmd_o.div_step = !first;
            if (last) state_d = ST_VEL;
          end
        endcase
      end
      ST_SUM: begin
        cmd_o.d_load = 1'b1;
        state_d      = ST_CHK;
      end
      ST_CHK: begin
        state_d = stat_i.skip ? ST_FIN : ST_ROOT;
      end
      ST_VEL: begin
        cmd_o.vel_upd = 1'b1;
        state_d       = ST_PMUL;
      end
      ST_PMUL: begin
        cmd_o.pos_mul = 1'b1;
        state_d       = ST_PADD;
      end
      ST_PADD: begin
        cmd_o.pos_upd = 1'b1;
        state_d       = ST_FIN;
      end
      ST_FIN: begin
        // Wait until the result register is free before loading it.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = cmd_o.out_load || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
endmodule

// ----- hw/rtl/point_gravity_euler_step_core.sv -----
// Each accepted item passes through four stepped phases: squares, square root, numerator
// and denominator products, and the division; a skipped step leaves after the squares.
// A new item is taken only once the result of the last one has been loaded.
// The next item is taken while a finished result still waits in the output register.
// Reset: asynchronous, active low; configuration takes its reset values and the body
// state is cleared to zero.
module point_gravity_euler_step_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pge_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pge_pkg::out_item_t            out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pge_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);
  import pge_pkg::*;

  pge_cmd_t  cmd;
  pge_stat_t stat;

  assign cfg_ready_o = 1'b1;

  pge_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  pge_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_item_i   (in_item_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );
endmodule

// ----- hw/rtl/pge_checker.sv -----
// Port-level checks for the core, attached by a bind statement.
module pge_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input pge_pkg::out_item_t out_item_o
);
  import pge_pkg::*;

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("result item dropped without being taken");

  // The core works on one item at a time.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is at work");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without an item at work");
endmodule

bind point_gravity_euler_step_core pge_checker u_pge_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

// ----- dv/point_gravity_euler_step_core_checker.sv -----
// Checker for the point-gravity Euler step core: models the body, predicts and compares results.
`timescale 1ns / 1ps
module point_gravity_euler_step_core_checker
  import pge_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_item_t             in_item_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  out_item_t            out_item_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output int                   errors_o,
  output int                   pending_o,
  output int                   skips_o
);

  logic signed [31:0] body_pos[3];
  logic signed [31:0] body_vel[3];
  logic [31:0]        grav_coef;
  logic [31:0]        min_dist_sqr;
  out_item_t          expected_q[$];
  int                 errors;
  int                 skips;

  assign errors_o  = errors;
  assign pending_o = expected_q.size();
  assign skips_o   = skips;

  function automatic logic signed [31:0] sat32(longint x);
    if (x > longint'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
    if (x < -longint'(64'h80000000)) return 32'sh80000000;
    return x[31:0];
  endfunction

  // One semi-implicit Euler step on the modeled body; returns the result item.
  function automatic out_item_t advance_body(in_item_t it);
    logic signed [31:0] att[3];
    longint             offs[3];
    logic [255:0]       mag[3];
    logic [255:0]       dsq;
    logic [255:0]       root;
    logic [255:0]       trial;
    logic [255:0]       den;
    logic [255:0]       gm;
    logic [255:0]       quo;
    longint             v;
    longint             vm;
    longint             dp;
    logic               skip;
    out_item_t          res;
    att[0] = it.attractor_x;
    att[1] = it.attractor_y;
    att[2] = it.attractor_z;
    dsq = '0;
    for (int i = 0; i < 3; i++) begin
      offs[i] = longint'(att[i]) - longint'(body_pos[i]);
      mag[i]  = 256'(offs[i] < 0 ? -offs[i] : offs[i]);
      dsq += mag[i] * mag[i];
    end
    skip = (dsq == '0) || (dsq < 256'(min_dist_sqr));
    if (!skip) begin
      root = '0;
      for (int b = 33; b >= 0; b--) begin
        trial = root | (256'(1) << b);
        if (trial * trial <= dsq) root = trial;
      end
      den = (dsq * root) << 32;
      gm  = 256'(grav_coef) * 256'(it.attractor_mass) * 256'(it.step_time);
      for (int i = 0; i < 3; i++) begin
        quo = (gm * mag[i]) / den;
        if (quo >= (256'(1) << 33)) quo = 256'(1) << 33;
        v = (offs[i] < 0) ? longint'(body_vel[i]) - longint'(quo[63:0])
                          : longint'(body_vel[i]) + longint'(quo[63:0]);
        body_vel[i] = sat32(v);
        vm = (body_vel[i] < 0) ? -longint'(body_vel[i]) : longint'(body_vel[i]);
        dp = (vm * longint'(it.step_time)) >>> 16;
        body_pos[i] = sat32((body_vel[i] < 0) ? longint'(body_pos[i]) - dp
                                              : longint'(body_pos[i]) + dp);
      end
    end
    res.pos_x_out    = body_pos[0];
    res.pos_y_out    = body_pos[1];
    res.pos_z_out    = body_pos[2];
    res.vel_x_out    = body_vel[0];
    res.vel_y_out    = body_vel[1];
    res.vel_z_out    = body_vel[2];
    res.step_skipped = skip;
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_item;
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        body_pos[i] = '0;
        body_vel[i] = '0;
      end
      grav_coef    = GRAV_COEF_RST;
      min_dist_sqr = MIN_DIST_SQR_RST;
      expected_q.delete();
      errors = 0;
      skips  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        // Init registers also load the body state at once; unknown indexes do nothing.
        if (cfg_index_i <= REG_INIT_POS_Z) body_pos[cfg_index_i] = cfg_data_i;
        else if (cfg_index_i <= REG_INIT_VEL_Z) body_vel[cfg_index_i - REG_INIT_VEL_X] = cfg_data_i;
        else if (cfg_index_i == REG_GRAV_COEF) grav_coef = cfg_data_i;
        else if (cfg_index_i == REG_MIN_DIST_SQR) min_dist_sqr = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result item arrived with no expectation pending");
          errors++;
        end else begin
          exp_item = expected_q.pop_front();
          check_field("pos_x_out", exp_item.pos_x_out, out_item_i.pos_x_out);
          check_field("pos_y_out", exp_item.pos_y_out, out_item_i.pos_y_out);
          check_field("pos_z_out", exp_item.pos_z_out, out_item_i.pos_z_out);
          check_field("vel_x_out", exp_item.vel_x_out, out_item_i.vel_x_out);
          check_field("vel_y_out", exp_item.vel_y_out, out_item_i.vel_y_out);
          check_field("vel_z_out", exp_item.vel_z_out, out_item_i.vel_z_out);
          check_field("step_skipped", 32'(exp_item.step_skipped),
                      32'(out_item_i.step_skipped));
          if (exp_item.step_skipped) skips++;
        end
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(advance_body(in_item_i));
    end
  end

endmodule

// ----- dv/point_gravity_euler_step_core_tb.sv -----
// Testbench top for the point-gravity Euler step core: stimulus, handshakes and verdict.
`timescale 1ns / 1ps
module point_gravity_euler_step_core_tb;
  import pge_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int LONG_HOLD      = 700;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  int                   errors;
  int                   pending;
  int                   skips;
  int                   items_sent;
  int                   cfg_writes;
  int                   idle_cycles;
  bit                   quiet;
  bit                   hold_armed;

  point_gravity_euler_step_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  point_gravity_euler_step_core_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_item_i  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .errors_o    (errors),
    .pending_o   (pending),
    .skips_o     (skips)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("point_gravity_euler_step_core_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stall bursts, plus one long hold-off while items keep coming.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Leaves valid high on return so that the next item can follow without a gap.
  task automatic send_item(in_item_t it);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic sender_gap(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    cfg_writes++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    @(negedge clk);
  endtask

  function automatic in_item_t make_item(logic [15:0] dt, logic [31:0] ax, logic [31:0] ay,
                                         logic [31:0] az, logic [47:0] mass);
    in_item_t it;
    it.step_time      = dt;
    it.attractor_x    = ax;
    it.attractor_y    = ay;
    it.attractor_z    = az;
    it.attractor_mass = mass;
    return it;
  endfunction

  // Mostly nearby attractors with varied mass and step, some anywhere in range.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h1FFFFF) - 32'h100000;
      2: return $urandom_range(0, 32'h1FFFFFF) - 32'h1000000;
      default: return $urandom_range(0, 511) - 256;
    endcase
  endfunction

  function automatic in_item_t rand_item();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    return make_item(16'($urandom >> $urandom_range(0, 16)), rand_coord(), rand_coord(),
                     rand_coord(), 48'(wide >> $urandom_range(0, 48)));
  endfunction

  task automatic random_config();
    for (int r = REG_INIT_POS_X; r <= REG_INIT_VEL_Z; r++) begin
      write_reg(CFG_IDX_W'(r), (r < REG_INIT_VEL_X) ? rand_coord() : ($urandom >> 8) - 32'h800000);
    end
    write_reg(REG_GRAV_COEF, $urandom);
    write_reg(REG_MIN_DIST_SQR, $urandom >> $urandom_range(8, 31));
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    items_sent  = 0;
    cfg_writes  = 0;
    quiet       = 1'b0;
    hold_armed  = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset configuration: zero distance, extreme fields, zero step and zero mass.
    send_item(make_item(16'hFFFF, 32'h0, 32'h0, 32'h0, 48'hFFFF_FFFF_FFFF));
    send_item(make_item(16'hFFFF, 32'h7FFFFFFF, 32'h0, 32'h0, 48'hFFFF_FFFF_FFFF));
    send_item(make_item(16'hFFFF, 32'h80000000, 32'h80000000, 32'h80000000,
                        48'hFFFF_FFFF_FFFF));
    send_item(make_item(16'h0, 32'h12345678, 32'hFEDCBA98, 32'h1, 48'h8000_0000_0000));
    send_item(make_item(16'h8000, 32'h00010000, 32'h0, 32'h0, 48'h0));
    send_item(make_item(16'h0001, 32'h00000020, 32'h7FFFFFFF, 32'h80000000, 48'h1));
    wait_drained();

    // Extreme registers: a step with min distance zero at zero offset must still skip.
    write_reg(REG_INIT_POS_X, 32'h7FFFFFFF);
    write_reg(REG_INIT_POS_Y, 32'h80000000);
    write_reg(REG_INIT_POS_Z, 32'h0);
    write_reg(REG_INIT_VEL_X, 32'h80000000);
    write_reg(REG_INIT_VEL_Y, 32'h7FFFFFFF);
    write_reg(REG_INIT_VEL_Z, 32'h1);
    write_reg(REG_GRAV_COEF, 32'hFFFFFFFF);
    write_reg(REG_MIN_DIST_SQR, 32'h0);
    // Index past the last register; the write must be dropped.
    write_reg(CFG_IDX_W'(REG_MIN_DIST_SQR) + 1'b1, 32'hDEADBEEF);
    write_reg(CFG_IDX_W'(REG_MIN_DIST_SQR) + 4'd8, 32'h0);
    send_item(make_item(16'hFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h0, 48'hFFFF_FFFF_FFFF));
    send_item(make_item(16'hFFFF, 32'h7FFFFFFF, 32'h80000001, 32'h0, 48'hFFFF_FFFF_FFFF));
    send_item(make_item(16'hFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                        48'hFFFF_FFFF_FFFF));
    send_item(make_item(16'h0100, 32'h1, 32'hFFFFFFFF, 32'h0, 48'h0000_0000_0001));
    wait_drained();
    write_reg(REG_GRAV_COEF, 32'h0);
    write_reg(REG_MIN_DIST_SQR, 32'hFFFFFFFF);
    send_item(make_item(16'hFFFF, 32'h0, 32'h0, 32'h0, 48'hFFFF_FFFF_FFFF));
    send_item(make_item(16'h5555, 32'h7FFF0000, 32'h0, 32'h0, 48'h0));
    send_item(make_item(16'hAAAA, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
                        48'hAAAA_5555_AAAA));
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      random_config();
      quiet = (phase == 3);
      for (int n = 0; n < 210; n++) begin
        if (phase == 1 && n == 40) hold_armed = 1'b1;
        if (phase == 2 && n == 100) wait_drained();
        send_item(rand_item());
        if (!quiet && $urandom_range(0, 7) == 0) sender_gap($urandom_range(1, 15));
      end
      wait_drained();
    end

    repeat (200) @(negedge clk);
    $display("Sent %0d items (%0d skipped steps) across %0d register writes,", items_sent,
             skips, cfg_writes);
    $display("including extreme settings, zero distance and a long result stall.");
    if (errors == 0 && pending == 0) begin
      $display("point_gravity_euler_step_core_tb passed");
    end else begin
      $display("point_gravity_euler_step_core_tb failed");
    end
    $finish;
  end

endmodule
